[sv/assert_macros.svh]
// assertion macros for checker modules, used by m3u_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[sv/m3u_pkg.sv]
// package for matrix3x3_unit: widths, operation and result kind codes
// no dependencies
package m3u_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int DIM = 3;
    localparam int NELEM = DIM * DIM;
    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [3:0] idx_t;
    typedef enum logic [2:0] {
        OP_WRITE_MAIN = 3'd0,
        OP_SCALE      = 3'd1,
        OP_TRANSPOSE  = 3'd2,
        OP_SARRUS     = 3'd3,
        OP_LAPLACE    = 3'd4,
        OP_WRITE_SEC  = 3'd5,
        OP_MULTIPLY   = 3'd6,
        OP_READ       = 3'd7
    } op_t;
    typedef enum logic [2:0] {
        KIND_ELEM   = 3'd0,
        KIND_POS    = 3'd1,
        KIND_NEG    = 3'd2,
        KIND_COF    = 3'd3,
        KIND_DET    = 3'd4
    } kind_t;
endpackage

[sv/matrix3x3_unit.sv]
// matrix3x3_unit: 3x3 main and second matrices in two synchronous memories, uses m3u_pkg
// one request at a time: writes go straight to memory, others first copy main into registers
// a stalled result holds the whole unit until it is taken
// rst_n asynchronous active low; both matrices cleared element by element after reset
module matrix3x3_unit
    import m3u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], row[4:3], column[6:5], value[38:7], replace[39]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0], out_row[4:3], out_column[6:5], result[38:7], pad[39]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RD2, S_CALC, S_WR, S_EMIT, S_NEXT
    } state_t;

    word_t main_mem [NELEM];
    word_t sec_mem [NELEM];

    state_t state_reg;
    op_t op_reg;
    logic [1:0] row_reg, col_reg;
    word_t val_reg;
    logic repl_reg;
    idx_t step_reg;
    logic [1:0] k_reg;
    idx_t ra_reg, rb_reg;
    word_t rda_reg, rdb_reg;
    word_t acc_reg, t_reg, p_reg, n_reg;
    word_t a_reg [NELEM];
    logic m_valid_reg, m_last_reg;
    logic [2:0] m_kind_reg;
    logic [1:0] m_row_reg, m_col_reg;
    word_t m_res_reg;
    logic we_main, we_sec;
    idx_t wa;
    word_t wd;

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tlast = m_last_reg;
    assign m_tdata = {1'b0, m_res_reg, m_col_reg, m_row_reg, m_kind_reg};

    function automatic idx_t ix(input logic [1:0] r, input logic [1:0] c);
        ix = idx_t'(r) * idx_t'(DIM) + idx_t'(c);
    endfunction

    function automatic logic [1:0] rof(input idx_t i);
        rof = (i >= idx_t'(6)) ? 2'd2 : (i >= idx_t'(3)) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] cof(input idx_t i);
        cof = 2'(i - idx_t'(rof(i)) * idx_t'(DIM));
    endfunction

    always_ff @(posedge clk)
    begin
        if (we_main)
        begin
            main_mem[wa] <= wd;
        end
        if (we_sec)
        begin
            sec_mem[wa] <= wd;
        end
        rda_reg <= main_mem[ra_reg];
        rdb_reg <= sec_mem[rb_reg];
    end

    // memory write control; the snapshot of main used by all non-write ops is loaded by reads
    always_comb
    begin
        we_main = 1'b0;
        we_sec = 1'b0;
        wa = step_reg;
        wd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                we_main = 1'b1;
                we_sec = 1'b1;
            end
            S_WR:
            begin
                case (op_reg)
                    OP_WRITE_MAIN:
                    begin
                        we_main = 1'b1;
                        wa = ix(row_reg, col_reg);
                        wd = val_reg;
                    end
                    OP_WRITE_SEC:
                    begin
                        we_sec = 1'b1;
                        wa = ix(row_reg, col_reg);
                        wd = val_reg;
                    end
                    OP_SCALE, OP_TRANSPOSE:
                    begin
                        we_main = 1'b1;
                        wd = m_res_reg;
                    end
                    OP_MULTIPLY:
                    begin
                        we_main = repl_reg;
                        wd = m_res_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // determinant terms computed from the snapshot with this truncating 32-bit multiply
    function automatic word_t mul(input word_t x, input word_t y);
        mul = x * y;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg <= 1'b0;
            ra_reg <= '0;
            rb_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (step_reg == idx_t'(NELEM - 1))
                    begin
                        step_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + idx_t'(1);
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg <= op_t'(s_tdata[2:0]);
                        row_reg <= s_tdata[4:3];
                        col_reg <= s_tdata[6:5];
                        val_reg <= s_tdata[38:7];
                        repl_reg <= s_tdata[39];
                        step_reg <= '0;
                        k_reg <= '0;
                        acc_reg <= '0;
                        t_reg <= '0;
                        case (op_t'(s_tdata[2:0]))
                            OP_WRITE_MAIN, OP_WRITE_SEC:
                            begin
                                if (s_tdata[4:3] != 2'd3 && s_tdata[6:5] != 2'd3)
                                begin
                                    state_reg <= S_WR;
                                end
                            end
                            default:
                            begin
                                ra_reg <= '0;
                                state_reg <= S_RD;
                            end
                        endcase
                    end
                end
                // load snapshot of main into a_reg one element at a time: S_RD issues the read, S_RD2 stores it
                S_RD:
                begin
                    ra_reg <= ra_reg + idx_t'(1);
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    a_reg[ra_reg - idx_t'(1)] <= rda_reg;
                    if (ra_reg == idx_t'(NELEM))
                    begin
                        step_reg <= '0;
                        ra_reg <= ix(2'd0, 2'd0);
                        rb_reg <= '0;
                        state_reg <= S_CALC;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_CALC:
                begin
                    if (!m_valid_reg)
                    begin
                        m_kind_reg <= KIND_ELEM;
                        m_row_reg <= rof(step_reg);
                        m_col_reg <= cof(step_reg);
                        m_last_reg <= 1'b0;
                        case (op_reg)
                            OP_SCALE:
                            begin
                                m_res_reg <= mul(a_reg[step_reg], val_reg);
                                state_reg <= S_WR;
                            end
                            OP_TRANSPOSE:
                            begin
                                m_res_reg <= a_reg[ix(cof(step_reg), rof(step_reg))];
                                state_reg <= S_WR;
                            end
                            OP_READ:
                            begin
                                m_res_reg <= a_reg[step_reg];
                                state_reg <= S_EMIT;
                            end
                            OP_MULTIPLY:
                            begin
                                // issue read of second[k][j], then accumulate
                                rb_reg <= ix(k_reg, cof(step_reg));
                                state_reg <= S_NEXT;
                            end
                            OP_SARRUS:
                            begin
                                // three steps of partial products, then emits
                                state_reg <= S_NEXT;
                            end
                            default:
                            begin
                                state_reg <= S_NEXT;
                            end
                        endcase
                    end
                end
                S_NEXT:
                begin
                    case (op_reg)
                        OP_MULTIPLY:
                        begin
                            if (k_reg == 2'd3)
                            begin
                                m_res_reg <= acc_reg;
                                acc_reg <= '0;
                                k_reg <= '0;
                                state_reg <= S_WR;
                            end
                            else if (t_reg == word_t'(1))
                            begin
                                acc_reg <= acc_reg
                                    + mul(a_reg[ix(rof(step_reg), k_reg)], rdb_reg);
                                k_reg <= k_reg + 2'd1;
                                t_reg <= '0;
                                state_reg <= S_CALC;
                            end
                            else
                            begin
                                t_reg <= word_t'(1);
                            end
                        end
                        OP_SARRUS:
                        begin
                            case (k_reg)
                                2'd0:
                                begin
                                    p_reg <= mul(a_reg[0], a_reg[4]);
                                    n_reg <= mul(a_reg[2], a_reg[4]);
                                    t_reg <= mul(a_reg[1], a_reg[5]);
                                    acc_reg <= mul(a_reg[2], a_reg[3]);
                                    k_reg <= 2'd1;
                                end
                                2'd1:
                                begin
                                    p_reg <= mul(p_reg, a_reg[8]) + mul(t_reg, a_reg[6])
                                        + mul(acc_reg, a_reg[7]);
                                    k_reg <= 2'd2;
                                    t_reg <= mul(a_reg[0], a_reg[5]);
                                    acc_reg <= mul(a_reg[1], a_reg[3]);
                                end
                                default:
                                begin
                                    n_reg <= '0 - mul(n_reg, a_reg[6])
                                        - mul(t_reg, a_reg[7]) - mul(acc_reg, a_reg[8]);
                                    k_reg <= '0;
                                    step_reg <= '0;
                                    state_reg <= S_EMIT;
                                    m_kind_reg <= KIND_POS;
                                    m_row_reg <= '0;
                                    m_col_reg <= '0;
                                end
                            endcase
                        end
                        default:
                        begin
                            case (k_reg)
                                2'd0:
                                begin
                                    p_reg <= mul(a_reg[4], a_reg[8]) - mul(a_reg[7], a_reg[5]);
                                    n_reg <= mul(a_reg[1], a_reg[8]) - mul(a_reg[2], a_reg[7]);
                                    t_reg <= mul(a_reg[1], a_reg[5]) - mul(a_reg[4], a_reg[2]);
                                    k_reg <= 2'd1;
                                end
                                default:
                                begin
                                    p_reg <= mul(a_reg[0], p_reg);
                                    n_reg <= '0 - mul(a_reg[3], n_reg);
                                    t_reg <= mul(a_reg[6], t_reg);
                                    k_reg <= '0;
                                    step_reg <= '0;
                                    state_reg <= S_EMIT;
                                    m_kind_reg <= KIND_COF;
                                    m_row_reg <= '0;
                                    m_col_reg <= '0;
                                end
                            endcase
                        end
                    endcase
                end
                S_WR:
                begin
                    if (op_reg == OP_WRITE_MAIN || op_reg == OP_WRITE_SEC)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg;
                        m_kind_reg <= KIND_ELEM;
                        m_row_reg <= rof(step_reg);
                        m_col_reg <= cof(step_reg);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!m_valid_reg)
                    begin
                        m_valid_reg <= 1'b1;
                        if (op_reg == OP_SARRUS)
                        begin
                            case (step_reg)
                                idx_t'(0): m_res_reg <= p_reg;
                                idx_t'(1):
                                begin
                                    m_res_reg <= n_reg;
                                    m_kind_reg <= KIND_NEG;
                                end
                                default:
                                begin
                                    m_res_reg <= p_reg + n_reg;
                                    m_kind_reg <= KIND_DET;
                                end
                            endcase
                            m_last_reg <= (step_reg == idx_t'(2));
                            if (step_reg == idx_t'(2))
                            begin
                                state_reg <= S_IDLE;
                            end
                            step_reg <= step_reg + idx_t'(1);
                        end
                        else if (op_reg == OP_LAPLACE)
                        begin
                            case (step_reg)
                                idx_t'(0):
                                begin
                                    m_res_reg <= p_reg;
                                    m_kind_reg <= KIND_COF;
                                    m_row_reg <= step_reg[1:0];
                                end
                                idx_t'(1):
                                begin
                                    m_res_reg <= n_reg;
                                    m_kind_reg <= KIND_COF;
                                    m_row_reg <= step_reg[1:0];
                                end
                                idx_t'(2):
                                begin
                                    m_res_reg <= t_reg;
                                    m_kind_reg <= KIND_COF;
                                    m_row_reg <= step_reg[1:0];
                                end
                                default:
                                begin
                                    m_res_reg <= p_reg + n_reg + t_reg;
                                    m_kind_reg <= KIND_DET;
                                    m_row_reg <= '0;
                                end
                            endcase
                            m_last_reg <= (step_reg == idx_t'(3));
                            if (step_reg == idx_t'(3))
                            begin
                                state_reg <= S_IDLE;
                            end
                            step_reg <= step_reg + idx_t'(1);
                        end
                        else
                        begin
                            m_last_reg <= (step_reg == idx_t'(NELEM - 1));
                            if (step_reg == idx_t'(NELEM - 1))
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                step_reg <= step_reg + idx_t'(1);
                                state_reg <= S_CALC;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[sv/m3u_checker.sv]
// port-level checker for matrix3x3_unit, bound into every matrix3x3_unit instance
// depends on assert_macros.svh and m3u_pkg
`include "assert_macros.svh"
module m3u_checker
    import m3u_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
    `CHK_IMPL(a_kind, clk, rst_n, m_tvalid, m_tdata[2:0] <= KIND_DET, "bad result kind")
    `CHK_IMPL(a_excl, clk, rst_n, s_tready, !m_tvalid, "request taken while result pending")
    `CHK_IMPL(a_det_last, clk, rst_n, m_tvalid && m_tdata[2:0] == KIND_DET, m_tlast, "determinant not last")
endmodule

bind matrix3x3_unit m3u_checker u_chk (.*);
